[rtl/tgarle_pkg.sv]
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
package tgarle_pkg;

  // Image size limits
  localparam logic [12:0] MAX_DIM   = 13'd4096;
  localparam logic [12:0] MIN_WIDTH = 13'd128;
  localparam logic [12:0] MIN_HEIGHT = 13'd1;

  // Packet header split point
  localparam logic [7:0] RUN_FLAG = 8'd128;

  // Job queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_BPP        = 2'd0,
    REG_WIDTH      = 2'd1,
    REG_HEIGHT     = 2'd2,
    REG_COMPRESSED = 2'd3
  } reg_idx_t;

  // Decoded configuration seen by front and back
  typedef struct packed {
    logic        bpp4;
    logic        compressed;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  // One queue entry: an optional position clear and an optional pixel job
  typedef struct packed {
    logic       clear;
    logic       has_pix;
    logic [7:0] len;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } job_t;

endpackage
`default_nettype wire

[rtl/tgarle_front.sv]
// Front end: packet header parsing and pixel byte assembly.
`timescale 1ns / 1ps
`default_nettype none
module tgarle_front (
  input  wire               clk,
  input  wire               rst_n,
  input  tgarle_pkg::cfg_t  cfg,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_data_byte,
  input  wire               in_start_image,
  input  wire               q_full,
  output logic              q_push,
  output tgarle_pkg::job_t  q_job
);

  logic        expect_header_r, expect_header_nxt;
  logic        packet_is_run_r, packet_is_run_nxt;
  logic [7:0]  pixels_left_r, pixels_left_nxt;
  logic [1:0]  byte_in_pixel_r, byte_in_pixel_nxt;
  logic [23:0] pixel_bytes_r, pixel_bytes_nxt;

  logic        accept;
  logic        eh, run;
  logic [7:0]  left;
  logic [1:0]  bip;
  logic [23:0] pix;
  logic [2:0]  bpp;
  logic        pix_done;
  logic [7:0]  len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bpp      = cfg.bpp4 ? 3'd4 : 3'd3;

  always_comb begin
    // start_image clears the packet state before this beat is used
    eh   = in_start_image ? 1'b1  : expect_header_r;
    run  = in_start_image ? 1'b0  : packet_is_run_r;
    left = in_start_image ? 8'd0  : pixels_left_r;
    bip  = in_start_image ? 2'd0  : byte_in_pixel_r;
    pix  = in_start_image ? 24'd0 : pixel_bytes_r;

    expect_header_nxt = expect_header_r;
    packet_is_run_nxt = packet_is_run_r;
    pixels_left_nxt   = pixels_left_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    pixel_bytes_nxt   = pixel_bytes_r;
    pix_done          = 1'b0;
    len               = 8'd1;

    if (accept) begin
      expect_header_nxt = eh;
      packet_is_run_nxt = run;
      pixels_left_nxt   = left;
      byte_in_pixel_nxt = bip;
      pixel_bytes_nxt   = pix;
      if (cfg.compressed && eh) begin
        // packet header
        if (in_data_byte < tgarle_pkg::RUN_FLAG) begin
          packet_is_run_nxt = 1'b0;
          pixels_left_nxt   = in_data_byte + 8'd1;
        end else begin
          packet_is_run_nxt = 1'b1;
          pixels_left_nxt   = in_data_byte - 8'd127;
        end
        expect_header_nxt = 1'b0;
      end else if ({1'b0, bip} + 3'd1 < bpp) begin
        // collect a pixel byte; a fourth byte position falls outside 24 bits
        case (bip)
          2'd0:    pixel_bytes_nxt = {pix[23:8], in_data_byte};
          2'd1:    pixel_bytes_nxt = {pix[23:16], in_data_byte, pix[7:0]};
          2'd2:    pixel_bytes_nxt = {in_data_byte, pix[15:0]};
          default: pixel_bytes_nxt = pix;
        endcase
        byte_in_pixel_nxt = bip + 2'd1;
      end else begin
        // last byte of a pixel
        pix_done          = 1'b1;
        byte_in_pixel_nxt = 2'd0;
        pixel_bytes_nxt   = 24'd0;
        if (cfg.compressed) begin
          if (run && left != 8'd0) begin
            len = left;
          end
          pixels_left_nxt = (left > len) ? left - len : 8'd0;
          if (pixels_left_nxt == 8'd0) begin
            expect_header_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Queue entry
  always_comb begin
    q_push        = accept && (in_start_image || pix_done);
    q_job.clear   = in_start_image;
    q_job.has_pix = pix_done;
    q_job.len     = len;
    q_job.blue    = pix[7:0];
    q_job.green   = pix[15:8];
    q_job.red     = cfg.bpp4 ? pix[23:16] : in_data_byte;
    q_job.alpha   = cfg.bpp4 ? in_data_byte : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      packet_is_run_r <= 1'b0;
      pixels_left_r   <= 8'd0;
      byte_in_pixel_r <= 2'd0;
      pixel_bytes_r   <= 24'd0;
    end else begin
      expect_header_r <= expect_header_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      pixels_left_r   <= pixels_left_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      pixel_bytes_r   <= pixel_bytes_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/tgarle_queue.sv]
// Small job queue between the front end and the segment back end.
`timescale 1ns / 1ps
`default_nettype none
module tgarle_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  tgarle_pkg::job_t  push_job,
  input  wire               pop,
  output tgarle_pkg::job_t  head,
  output logic              head_valid,
  output logic              full
);

  tgarle_pkg::job_t               mem_r [tgarle_pkg::QUEUE_DEPTH];
  logic [tgarle_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tgarle_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tgarle_pkg::QPTR_W:0]    count_r, count_nxt;
  logic                           do_pop;

  assign full       = (count_r == (tgarle_pkg::QPTR_W+1)'(tgarle_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointers wrap naturally since the depth is a power of two
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/tgarle_back.sv]
// Back end: image position tracking, row-end splitting and output register.
`timescale 1ns / 1ps
`default_nettype none
module tgarle_back (
  input  wire               clk,
  input  wire               rst_n,
  input  tgarle_pkg::cfg_t  cfg,
  input  tgarle_pkg::job_t  head,
  input  wire               head_valid,
  output logic              head_pop,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [11:0]       out_row,
  output logic [11:0]       out_column,
  output logic [7:0]        out_run_length,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic              out_last_segment,
  output logic              out_image_done
);

  // Position state; row counts completed rows
  logic [12:0] col_r, col_nxt;
  logic [12:0] row_r, row_nxt;
  logic        fin_r, fin_nxt;
  logic        mid_r, mid_nxt;
  logic [7:0]  rem_r, rem_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] row_o_r, col_o_r;
  logic [7:0]  len_o_r, red_o_r, green_o_r, blue_o_r, alpha_o_r;
  logic        last_o_r, done_o_r;

  logic        can_out, fresh, emit, step, last, done;
  logic [12:0] col_e, row_e, c1, r1, space, c2, r2, vrow;
  logic        fin_e;
  logic [7:0]  rem, seg;

  assign can_out = !out_valid_r || out_ready;
  assign fresh   = head.clear && !mid_r;

  always_comb begin
    // position after an optional clear, then the wrap at a row end
    col_e = fresh ? 13'd0 : col_r;
    row_e = fresh ? 13'd0 : row_r;
    fin_e = fresh ? 1'b0  : fin_r;
    if (col_e >= cfg.width) begin
      c1 = 13'd0;
      r1 = row_e + 13'd1;
    end else begin
      c1 = col_e;
      r1 = row_e;
    end

    rem   = mid_r ? rem_r : head.len;
    space = cfg.width - c1;
    seg   = ({5'd0, rem} < space) ? rem : space[7:0];
    c2    = c1 + {5'd0, seg};
    r2    = r1 + 13'd1;
    done  = (c2 >= cfg.width) && (r2 >= cfg.height);
    last  = (seg == rem) || done;
    vrow  = cfg.compressed ? cfg.height - 13'd1 - r1 : r1;

    emit = head.has_pix && !fin_e && (r1 < cfg.height);
    step = head_valid && (can_out || !emit);

    col_nxt  = col_r;
    row_nxt  = row_r;
    fin_nxt  = fin_r;
    mid_nxt  = mid_r;
    rem_nxt  = rem_r;
    head_pop = 1'b0;

    if (step) begin
      col_nxt  = col_e;
      row_nxt  = row_e;
      fin_nxt  = fin_e;
      head_pop = 1'b1;
      if (head.has_pix && !fin_e) begin
        if (!emit) begin
          // the image is already full
          col_nxt = c1;
          row_nxt = r1;
          fin_nxt = 1'b1;
        end else begin
          if (c2 >= cfg.width) begin
            col_nxt = 13'd0;
            row_nxt = r2;
            fin_nxt = done;
          end else begin
            col_nxt = c2;
            row_nxt = r1;
          end
          // a run crossing a row end is split into two segments; the head is popped with the last
          head_pop = last;
          mid_nxt  = !last;
          rem_nxt  = rem - seg;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (can_out) begin
      out_valid_nxt = step && emit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (can_out && step && emit) begin
      row_o_r   <= vrow[11:0];
      col_o_r   <= c1[11:0];
      len_o_r   <= seg;
      red_o_r   <= head.red;
      green_o_r <= head.green;
      blue_o_r  <= head.blue;
      alpha_o_r <= head.alpha;
      last_o_r  <= last;
      done_o_r  <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 13'd0;
      row_r       <= 13'd0;
      fin_r       <= 1'b0;
      mid_r       <= 1'b0;
      rem_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fin_r       <= fin_nxt;
      mid_r       <= mid_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row          = row_o_r;
  assign out_column       = col_o_r;
  assign out_run_length   = len_o_r;
  assign out_red          = red_o_r;
  assign out_green        = green_o_r;
  assign out_blue         = blue_o_r;
  assign out_alpha        = alpha_o_r;
  assign out_last_segment = last_o_r;
  assign out_image_done   = done_o_r;

endmodule
`default_nettype wire

[rtl/tga_rle_pixel_decoder.sv]
// TGA run-length pixel decoder: one data byte per beat in, one color segment per beat out.
// A completed pixel passes the job queue, then the segment output register, before out_valid.
// Throughput: one byte per cycle while the queue has room; row-crossing runs give two segments.
// A four-entry job queue lets the byte front end run ahead of the segment unit.
// Reset (rst_n low, synchronous): 32-bit pixels, width 128, height 1, compressed,
// decoder waiting for a packet header at row 0, column 0, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_pixel_decoder (
  input  wire         clk,
  input  wire         rst_n,
  // APB configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_start_image,
  // segment output
  output logic        out_valid,
  input  wire         out_ready,
  output logic [11:0] out_row,
  output logic [11:0] out_column,
  output logic [7:0]  out_run_length,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last_segment,
  output logic        out_image_done
);

  logic [2:0]  bpp_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic        compressed_r;

  tgarle_pkg::reg_idx_t idx;
  tgarle_pkg::cfg_t     cfg;
  tgarle_pkg::job_t     push_job, head;
  logic                 wr_en, q_full, q_push, head_valid, head_pop;

  assign pready = 1'b1;
  assign idx    = tgarle_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= 3'd4;
      width_r      <= 13'd128;
      height_r     <= 13'd1;
      compressed_r <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        tgarle_pkg::REG_BPP:        bpp_r        <= pwdata[2:0];
        tgarle_pkg::REG_WIDTH:      width_r      <= pwdata[12:0];
        tgarle_pkg::REG_HEIGHT:     height_r     <= pwdata[12:0];
        tgarle_pkg::REG_COMPRESSED: compressed_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (idx)
      tgarle_pkg::REG_BPP:        prdata = {29'd0, bpp_r};
      tgarle_pkg::REG_WIDTH:      prdata = {19'd0, width_r};
      tgarle_pkg::REG_HEIGHT:     prdata = {19'd0, height_r};
      tgarle_pkg::REG_COMPRESSED: prdata = {31'd0, compressed_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // Decoded configuration with size clamping
  always_comb begin
    cfg.bpp4       = (bpp_r == 3'd4);
    cfg.compressed = compressed_r;
    if (width_r < tgarle_pkg::MIN_WIDTH) begin
      cfg.width = tgarle_pkg::MIN_WIDTH;
    end else if (width_r > tgarle_pkg::MAX_DIM) begin
      cfg.width = tgarle_pkg::MAX_DIM;
    end else begin
      cfg.width = width_r;
    end
    if (height_r < tgarle_pkg::MIN_HEIGHT) begin
      cfg.height = tgarle_pkg::MIN_HEIGHT;
    end else if (height_r > tgarle_pkg::MAX_DIM) begin
      cfg.height = tgarle_pkg::MAX_DIM;
    end else begin
      cfg.height = height_r;
    end
  end

  tgarle_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_start_image (in_start_image),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  tgarle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (head_pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  tgarle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head             (head),
    .head_valid       (head_valid),
    .head_pop         (head_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_run_length   (out_run_length),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_last_segment (out_last_segment),
    .out_image_done   (out_image_done)
  );

endmodule
`default_nettype wire
